// ===== rtl/inline_markup_style_tagger_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the markup tagger checker
// ---------------------------------------------------------------------------
`ifndef INLINE_MARKUP_STYLE_TAGGER_ASSERT_SVH
`define INLINE_MARKUP_STYLE_TAGGER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define IMST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define IMST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/imst_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imst_pkg
// Shared types and character constants of the inline markup tagger.
// ---------------------------------------------------------------------------
package imst_pkg;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // scanner position relative to a tag
    typedef enum logic [2:0] {
        PH_IDLE, PH_LT, PH_SLASH, PH_NAME, PH_SLASHGT
    } phase_t;

    // tag kinds; formatting kinds fit in the low three bits
    typedef enum logic [3:0] {
        TG_NONE, TG_SUP, TG_SUB, TG_B, TG_I, TG_U, TG_S, TG_BR, TG_P
    } tag_t;

    // what the current byte does after any flush
    typedef enum logic [2:0] {
        ACT_EMIT, ACT_START_LT, ACT_HOLD, ACT_DROP, ACT_TAG
    } act_t;

    typedef struct packed {
        logic   flush;
        act_t   act;
        phase_t hold_phase;
        tag_t   tag;
        logic   closing;
        logic   slash;
    } dec_t;

    typedef struct packed {
        logic load;
        logic flush_emit;
        logic flush_final;
        logic act_exec;
        logic search_step;
        logic rebuild_step;
        logic mark_emit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic flush_now;
        logic needs_out;
        logic needs_search;
        logic last;
        logic pend_last;
        logic pend_empty;
        logic search_end;
        logic search_hit;
        logic rebuild_end;
        logic emitted;
        logic out_free;
    } sts_t;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FLUSH1  = 7'b0000010,
        S_ACT     = 7'b0000100,
        S_SEARCH  = 7'b0001000,
        S_REBUILD = 7'b0010000,
        S_TAIL    = 7'b0100000,
        S_FLUSH2  = 7'b1000000
    } state_t;

endpackage

// ===== rtl/imst_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imst_ctrl
// Sequencer: steps one request through flush, action, stack search and
// rebuild, and end-of-text handling.
// ---------------------------------------------------------------------------
module imst_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          in_ready,
    input  imst_pkg::sts_t sts,
    output imst_pkg::cmd_t cmd
);
    import imst_pkg::*;

    state_t state_reg, state_next;
    state_t after_st;

    assign after_st = sts.last ? S_TAIL : S_IDLE;
    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.flush_now ? S_FLUSH1 : S_ACT;
                end
            end
            S_FLUSH1: begin
                if (sts.out_free) begin
                    cmd.flush_emit = 1'b1;
                    if (sts.pend_last) state_next = S_ACT;
                end
            end
            S_ACT: begin
                if (!sts.needs_out || sts.out_free) begin
                    cmd.act_exec = 1'b1;
                    state_next   = sts.needs_search ? S_SEARCH : after_st;
                end
            end
            S_SEARCH: begin
                cmd.search_step = 1'b1;
                if (sts.search_end)      state_next = after_st;
                else if (sts.search_hit) state_next = S_REBUILD;
            end
            S_REBUILD: begin
                cmd.rebuild_step = 1'b1;
                if (sts.rebuild_end) state_next = after_st;
            end
            S_TAIL: begin
                if (!sts.pend_empty) begin
                    state_next = S_FLUSH2;
                end else if (sts.emitted) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.mark_emit = 1'b1;
                    cmd.finish    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FLUSH2: begin
                if (sts.out_free) begin
                    cmd.flush_emit  = 1'b1;
                    cmd.flush_final = 1'b1;
                    if (sts.pend_last) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ===== rtl/imst_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imst_dpath
// Datapath: tag scanner state, held bytes, style stack with cached flags,
// paragraph state and the output register.
// ---------------------------------------------------------------------------
module imst_dpath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic [7:0]     in_char,
    input  logic           in_last,
    input  imst_pkg::cmd_t cmd,
    output imst_pkg::sts_t sts,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [15:0]    m_tdata,
    output logic           m_tuser,
    output logic           m_tlast
);
    import imst_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // style flag bits: 0 bold, 1 italic, 2 underline, 3 strike, 4 sup, 5 sub
    function automatic logic [5:0] add_tag(input logic [5:0] f, input logic [2:0] t);
        logic [5:0] r;
        r = f;
        case (t)
            TG_B[2:0]:   r[0] = 1'b1;
            TG_I[2:0]:   r[1] = 1'b1;
            TG_U[2:0]:   r[2] = 1'b1;
            TG_S[2:0]:   r[3] = 1'b1;
            TG_SUP[2:0]: r[5:4] = 2'b01;
            TG_SUB[2:0]: r[5:4] = 2'b10;
            default:     r = f;
        endcase
        return r;
    endfunction

    logic                plain_reg;
    phase_t              phase_reg;
    logic [7:0]          pend_reg [5];
    logic [2:0]          pcount_reg;
    logic [2:0]          fidx_reg;
    logic [2:0]          stack_reg [STACK_DEPTH];
    logic [CNT_W-1:0]    scount_reg;
    logic [CNT_W-1:0]    sidx_reg;
    logic [CNT_W-1:0]    j_reg;
    logic [IDX_W-1:0]    hit_reg;
    logic                reb_reg;
    logic [5:0]          flags_reg;
    logic                para_reg, brk_reg, ovf_reg, emitted_reg;
    logic [7:0]          c_reg;
    logic                last_reg;
    dec_t                dec_reg;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;
    logic                out_user_reg, out_last_reg;

    // ---- decode of the incoming byte against the scanner state ----
    dec_t       dec_now;
    logic       in_alpha;
    logic [2:0] nstart, nlen;
    logic [7:0] la, lb, lc;
    tag_t       cls;
    act_t       idle_act;

    assign in_alpha = ((in_char >= 8'h41) && (in_char <= 8'h5A))
                   || ((in_char >= 8'h61) && (in_char <= 8'h7A));
    assign nstart   = ((pcount_reg >= 3'd2) && (pend_reg[1] == CH_SLASH)) ? 3'd2 : 3'd1;
    assign nlen     = pcount_reg - nstart;
    // held name bytes are letters, so forcing the case bit lowercases them
    assign la       = pend_reg[nstart] | CASE_BIT;
    assign lb       = pend_reg[nstart + 3'd1] | CASE_BIT;
    assign lc       = pend_reg[nstart + 3'd2] | CASE_BIT;
    assign idle_act = (in_char == CH_LT) ? ACT_START_LT : ACT_EMIT;

    always_comb begin
        cls = TG_NONE;
        case (nlen)
            3'd1: begin
                if (la == CH_LC_B)      cls = TG_B;
                else if (la == CH_LC_I) cls = TG_I;
                else if (la == CH_LC_U) cls = TG_U;
                else if (la == CH_LC_S) cls = TG_S;
                else if (la == CH_LC_P) cls = TG_P;
            end
            3'd2: if (la == CH_LC_B && lb == CH_LC_R) cls = TG_BR;
            3'd3: begin
                if (la == CH_LC_S && lb == CH_LC_U) begin
                    if (lc == CH_LC_P)      cls = TG_SUP;
                    else if (lc == CH_LC_B) cls = TG_SUB;
                end
            end
            default: cls = TG_NONE;
        endcase
    end

    always_comb begin
        dec_now            = '0;
        dec_now.act        = idle_act;
        dec_now.hold_phase = PH_IDLE;
        dec_now.tag        = cls;
        dec_now.closing    = (nstart == 3'd2);
        dec_now.slash      = (in_char == CH_SLASH);
        case (phase_reg)
            PH_LT: begin
                if (in_char == CH_SLASH) begin
                    dec_now.act = ACT_HOLD; dec_now.hold_phase = PH_SLASH;
                end else if (in_alpha) begin
                    dec_now.act = ACT_HOLD; dec_now.hold_phase = PH_NAME;
                end else begin
                    dec_now.flush = 1'b1;
                end
            end
            PH_SLASH: begin
                if (in_alpha) begin
                    dec_now.act = ACT_HOLD; dec_now.hold_phase = PH_NAME;
                end else begin
                    dec_now.flush = 1'b1;
                end
            end
            PH_NAME: begin
                if (in_alpha && nlen < 3'd3) begin
                    dec_now.act = ACT_HOLD; dec_now.hold_phase = PH_NAME;
                end else if ((in_char == CH_GT || in_char == CH_SLASH) && cls != TG_NONE) begin
                    dec_now.act = ACT_TAG;
                end else begin
                    dec_now.flush = 1'b1;
                end
            end
            PH_SLASHGT: begin
                if (in_char == CH_GT) dec_now.act = ACT_DROP;
                else                  dec_now.flush = 1'b1;
            end
            default: dec_now.act = idle_act;
        endcase
    end

    // ---- stack read port: search walks down, rebuild walks up ----
    logic [CNT_W-1:0] sidx_m1, j_p1, scount_m1;
    logic [IDX_W-1:0] rd_idx;
    logic [2:0]       rd_val;
    logic             shift_now;

    assign sidx_m1   = sidx_reg - CNT_W'(1);
    assign j_p1      = j_reg + CNT_W'(1);
    assign scount_m1 = scount_reg - CNT_W'(1);
    assign shift_now = (j_reg >= CNT_W'(hit_reg));
    assign rd_idx    = !reb_reg ? sidx_m1[IDX_W-1:0]
                     : (shift_now ? j_p1[IDX_W-1:0] : j_reg[IDX_W-1:0]);
    assign rd_val    = stack_reg[rd_idx];

    // ---- status to the sequencer ----
    logic tag_fmt;
    assign tag_fmt = (dec_reg.tag != TG_BR) && (dec_reg.tag != TG_P);

    always_comb begin
        sts              = '0;
        sts.flush_now    = dec_now.flush;
        sts.needs_out    = (dec_reg.act == ACT_EMIT)
                        || (dec_reg.act == ACT_TAG && dec_reg.tag == TG_BR);
        sts.needs_search = (dec_reg.act == ACT_TAG) && dec_reg.closing && !plain_reg && tag_fmt;
        sts.last         = last_reg;
        sts.pend_last    = (fidx_reg == pcount_reg - 3'd1);
        sts.pend_empty   = (pcount_reg == 3'd0);
        sts.search_end   = (sidx_reg == '0);
        sts.search_hit   = (sidx_reg != '0) && (rd_val == dec_reg.tag[2:0]);
        sts.rebuild_end  = (j_reg == scount_m1);
        sts.emitted      = emitted_reg;
        sts.out_free     = !out_valid_reg || m_tready;
    end

    // ---- emission select ----
    logic       emit_en, emit_bare, emit_last;
    logic [7:0] emit_char;
    logic       emit_plain;
    logic [5:0] emit_flags;
    logic       emit_np;

    always_comb begin
        emit_en   = 1'b0;
        emit_bare = 1'b0;
        emit_last = 1'b0;
        emit_char = 8'h00;
        if (cmd.flush_emit) begin
            emit_en   = 1'b1;
            emit_char = pend_reg[fidx_reg];
            emit_last = cmd.flush_final && sts.pend_last;
        end else if (cmd.act_exec && dec_reg.act == ACT_EMIT) begin
            emit_en   = 1'b1;
            emit_char = c_reg;
            emit_last = last_reg;
        end else if (cmd.act_exec && dec_reg.act == ACT_TAG && dec_reg.tag == TG_BR) begin
            emit_en   = 1'b1;
            emit_char = plain_reg ? CH_SPACE : CH_NL;
            emit_last = last_reg && !dec_reg.slash;
        end else if (cmd.mark_emit) begin
            emit_en   = 1'b1;
            emit_bare = 1'b1;
            emit_last = 1'b1;
        end
    end

    assign emit_plain = plain_reg || emit_bare;
    assign emit_flags = emit_plain ? 6'd0 : flags_reg;
    assign emit_np    = emit_plain ? 1'b0 : brk_reg;

    // ---- control state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plain_reg     <= 1'b0;
            phase_reg     <= PH_IDLE;
            pcount_reg    <= 3'd0;
            fidx_reg      <= 3'd0;
            scount_reg    <= '0;
            sidx_reg      <= '0;
            j_reg         <= '0;
            hit_reg       <= '0;
            reb_reg       <= 1'b0;
            flags_reg     <= 6'd0;
            para_reg      <= 1'b0;
            brk_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) plain_reg <= cfg_wr_data;

            // output register
            if (emit_en)       out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            if (cmd.load) begin
                emitted_reg <= 1'b0;
                fidx_reg    <= 3'd0;
            end

            // any real byte outside plain mode counts as paragraph content
            if (emit_en) begin
                emitted_reg <= 1'b1;
                if (!emit_plain && !cmd.finish) begin
                    brk_reg  <= 1'b0;
                    para_reg <= 1'b1;
                end
            end

            // held bytes go out in order, then scanning restarts
            if (cmd.flush_emit && !cmd.finish) begin
                if (sts.pend_last) begin
                    fidx_reg   <= 3'd0;
                    pcount_reg <= 3'd0;
                    phase_reg  <= PH_IDLE;
                end else begin
                    fidx_reg <= fidx_reg + 3'd1;
                end
            end

            if (cmd.act_exec) begin
                case (dec_reg.act)
                    ACT_START_LT: begin
                        pcount_reg <= 3'd1;
                        phase_reg  <= PH_LT;
                    end
                    ACT_HOLD: begin
                        pcount_reg <= pcount_reg + 3'd1;
                        phase_reg  <= dec_reg.hold_phase;
                    end
                    ACT_DROP: begin
                        pcount_reg <= 3'd0;
                        phase_reg  <= PH_IDLE;
                    end
                    ACT_TAG: begin
                        pcount_reg <= dec_reg.slash ? 3'd1 : 3'd0;
                        phase_reg  <= dec_reg.slash ? PH_SLASHGT : PH_IDLE;
                        if (!plain_reg && dec_reg.tag == TG_P) begin
                            if (para_reg) begin
                                brk_reg  <= 1'b1;
                                para_reg <= 1'b0;
                            end
                        end else if (!plain_reg && tag_fmt) begin
                            if (dec_reg.closing) begin
                                sidx_reg <= scount_reg;
                            end else if (scount_reg < CNT_W'(STACK_DEPTH)) begin
                                scount_reg <= scount_reg + CNT_W'(1);
                                flags_reg  <= add_tag(flags_reg, dec_reg.tag[2:0]);
                            end else begin
                                ovf_reg <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // search for the topmost matching entry
            if (cmd.search_step && !sts.search_end) begin
                if (sts.search_hit) begin
                    reb_reg   <= 1'b1;
                    j_reg     <= '0;
                    hit_reg   <= sidx_m1[IDX_W-1:0];
                    flags_reg <= 6'd0;
                end else begin
                    sidx_reg <= sidx_m1;
                end
            end

            // close the gap and rebuild the cached flags bottom-up
            if (cmd.rebuild_step) begin
                if (sts.rebuild_end) begin
                    scount_reg <= scount_m1;
                    reb_reg    <= 1'b0;
                end else begin
                    flags_reg <= add_tag(flags_reg, rd_val);
                    j_reg     <= j_p1;
                end
            end

            // end of text clears the per-text state
            if (cmd.finish) begin
                phase_reg  <= PH_IDLE;
                pcount_reg <= 3'd0;
                fidx_reg   <= 3'd0;
                scount_reg <= '0;
                flags_reg  <= 6'd0;
                para_reg   <= 1'b0;
                brk_reg    <= 1'b0;
                ovf_reg    <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            c_reg    <= in_char;
            last_reg <= in_last;
            dec_reg  <= dec_now;
        end
        if (cmd.act_exec) begin
            if (dec_reg.act == ACT_START_LT)
                pend_reg[0] <= CH_LT;
            else if (dec_reg.act == ACT_HOLD)
                pend_reg[pcount_reg] <= c_reg;
            else if (dec_reg.act == ACT_TAG && dec_reg.slash)
                pend_reg[0] <= CH_SLASH;
        end
        if (cmd.act_exec && dec_reg.act == ACT_TAG && !dec_reg.closing && !plain_reg
                && tag_fmt && scount_reg < CNT_W'(STACK_DEPTH))
            stack_reg[scount_reg[IDX_W-1:0]] <= dec_reg.tag[2:0];
        else if (cmd.rebuild_step && !sts.rebuild_end && shift_now)
            stack_reg[j_reg[IDX_W-1:0]] <= rd_val;
        if (emit_en) begin
            out_data_reg <= {ovf_reg, emit_np, emit_flags, emit_bare ? 8'h00 : emit_char};
            out_user_reg <= !emit_bare;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/inline_markup_style_tagger.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// inline_markup_style_tagger
// Byte-stream markup tagger: strips sup/sub/b/i/u/s/br/p tags and tags each
// text byte with its style flags.
// ---------------------------------------------------------------------------
// Usage: one byte is taken per request, and a new one only once the block
// is idle again. A plain text byte is accepted, then emitted when the output
// register is free; a byte held inside a tag is accepted, then stored. Bytes
// released from a broken tag or at the end of the text go out in order while
// the output register is free; a closing step ends each text. A closing
// formatting tag walks the style stack, one entry per cycle from the top to
// the match, then once more from the bottom to close the gap and rebuild the
// cached flags. A bare end marker (tuser low) closes a text whose last byte
// produced nothing. plain_text_mode is written through cfg_wr_en while the
// block is idle; the user must ensure this, as the block does not check it.
module inline_markup_style_tagger #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // plain_text_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_in
    input  logic        s_tlast,       // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] char_out, [8] bold, [9] italic, [10] underline, [11] strike,
    // [12] superscript, [13] subscript, [14] new_paragraph, [15] stack_overflow
    output logic [15:0] m_tdata,
    output logic        m_tuser,       // has_char
    output logic        m_tlast        // last_out
);
    import imst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    imst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    imst_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_char     (s_tdata),
        .in_last     (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== rtl/imst_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imst_checker
// Port-level checks on the result stream of the markup tagger.
// ---------------------------------------------------------------------------
`include "inline_markup_style_tagger_assert.svh"

module imst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    `IMST_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    // bare marker only ends a text
    `IMST_ASSERT_NOW(a_bare_last, m_tvalid && !m_tuser, m_tlast, "bare marker without last")
    // bare marker carries no byte, style or paragraph mark
    `IMST_ASSERT_NOW(a_bare_zero, m_tvalid && !m_tuser, m_tdata[14:0] == 15'd0, "bare marker not clear")
    // sup and sub are exclusive
    `IMST_ASSERT_NOW(a_sup_sub, m_tvalid, !(m_tdata[12] && m_tdata[13]), "sup and sub both set")

endmodule

bind inline_markup_style_tagger imst_checker u_imst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Markup tagger testbench
// Drives byte streams of text with sup/sub/b/i/u/s/br/p tags, whole, broken
// and random, through the tagger under random stalls on both sides. Every
// styled byte that comes out is compared with a behavioral model of the
// tag scanner, style stack and paragraph tracking.
// ---------------------------------------------------------------------------
module testbench;
    import imst_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int IDLE_LIMIT  = 4000;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       bold;
        logic       italic;
        logic       underline;
        logic       strike;
        logic       sup;
        logic       sub;
        logic       new_par;
        logic       ovf;
        logic       last;
    } styled_t;

    // one row of the directed table; chk set means exp is typed in
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       chk;
        styled_t    exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    always #6 aclk = ~aclk;

    inline_markup_style_tagger #(.STACK_DEPTH(STACK_DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // tagger model state
    logic       plain_mode;
    phase_t     phase;
    logic [7:0] held [5];
    int         held_cnt;
    tag_t       styles [STACK_DEPTH];
    int         style_cnt;
    logic       para_content;
    logic       para_break;
    logic       ovf_flag;

    styled_t    styled_q [$];
    row_t       pinned_q [$];
    int         produced = 0;
    int         errors = 0;
    logic       rx_quiet = 1'b0;
    logic       tx_quiet = 1'b0;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | CASE_BIT) : c;
    endfunction

    function automatic void model_clear();
        phase = PH_IDLE;
        held_cnt = 0;
        style_cnt = 0;
        para_content = 1'b0;
        para_break = 1'b0;
        ovf_flag = 1'b0;
    endfunction

    // append one expected result
    function automatic void queue_styled(styled_t r);
        styled_q = {styled_q, r};
        produced++;
    endfunction

    // styled byte with the flags of the current stack
    function automatic void put_styled(logic [7:0] c);
        styled_t r;
        logic    resolved;
        r = '0;
        resolved = 1'b0;
        r.ch = c;
        r.has = 1'b1;
        if (!plain_mode) begin
            for (int k = style_cnt - 1; k >= 0; k--) begin
                case (styles[k])
                    TG_B: r.bold = 1'b1;
                    TG_I: r.italic = 1'b1;
                    TG_U: r.underline = 1'b1;
                    TG_S: r.strike = 1'b1;
                    TG_SUP, TG_SUB: if (!resolved) begin
                        resolved = 1'b1;
                        if (styles[k] == TG_SUP) r.sup = 1'b1;
                        else r.sub = 1'b1;
                    end
                    default: ;
                endcase
            end
            r.new_par = para_break;
            para_break = 1'b0;
            para_content = 1'b1;
        end
        r.ovf = ovf_flag;
        queue_styled(r);
    endfunction

    function automatic void release_held();
        for (int k = 0; k < held_cnt; k++) put_styled(held[k]);
        held_cnt = 0;
        phase = PH_IDLE;
    endfunction

    function automatic void hold_byte(logic [7:0] c);
        if (held_cnt < 5) begin
            held[held_cnt] = c;
            held_cnt++;
        end
    endfunction

    function automatic void plain_byte(logic [7:0] c);
        if (c == CH_LT) begin
            held_cnt = 0;
            hold_byte(c);
            phase = PH_LT;
        end else begin
            put_styled(c);
        end
    endfunction

    function automatic int name_at();
        return (held_cnt >= 2 && held[1] == CH_SLASH) ? 2 : 1;
    endfunction

    function automatic tag_t held_tag();
        int         s, n;
        logic [7:0] a, b, c;
        s = name_at();
        if (held_cnt <= s || held_cnt > 5) return TG_NONE;
        n = held_cnt - s;
        a = lower(held[s]);
        b = n > 1 ? lower(held[s + 1]) : 8'h00;
        c = n > 2 ? lower(held[s + 2]) : 8'h00;
        if (n == 1) begin
            if (a == CH_LC_B) return TG_B;
            if (a == CH_LC_I) return TG_I;
            if (a == CH_LC_U) return TG_U;
            if (a == CH_LC_S) return TG_S;
            if (a == CH_LC_P) return TG_P;
        end else if (n == 2) begin
            if (a == CH_LC_B && b == CH_LC_R) return TG_BR;
        end else if (n == 3 && a == CH_LC_S && b == CH_LC_U) begin
            if (c == CH_LC_P) return TG_SUP;
            if (c == CH_LC_B) return TG_SUB;
        end
        return TG_NONE;
    endfunction

    function automatic void take_tag(tag_t t, logic closing);
        if (t == TG_BR) begin
            put_styled(plain_mode ? CH_SPACE : CH_NL);
            return;
        end
        if (plain_mode) return;
        if (t == TG_P) begin
            if (para_content) begin
                para_break = 1'b1;
                para_content = 1'b0;
            end
            return;
        end
        if (closing) begin
            for (int k = style_cnt - 1; k >= 0; k--) begin
                if (styles[k] == t) begin
                    for (int j = k; j + 1 < style_cnt; j++) styles[j] = styles[j + 1];
                    style_cnt--;
                    return;
                end
            end
        end else if (style_cnt < STACK_DEPTH) begin
            styles[style_cnt] = t;
            style_cnt++;
        end else begin
            ovf_flag = 1'b1;
        end
    endfunction

    // one input byte: queue every styled byte it releases
    function automatic void tag_scan(logic [7:0] c, logic last);
        int   n0;
        tag_t t;
        logic closing;
        n0 = styled_q.size();
        case (phase)
            PH_LT:
                if (c == CH_SLASH) begin hold_byte(c); phase = PH_SLASH; end
                else if (is_letter(c)) begin hold_byte(c); phase = PH_NAME; end
                else begin release_held(); plain_byte(c); end
            PH_SLASH:
                if (is_letter(c)) begin hold_byte(c); phase = PH_NAME; end
                else begin release_held(); plain_byte(c); end
            PH_NAME:
                if (is_letter(c) && held_cnt - name_at() < 3) begin
                    hold_byte(c);
                end else if (c == CH_GT || c == CH_SLASH) begin
                    t = held_tag();
                    closing = name_at() == 2;
                    if (t == TG_NONE) begin
                        release_held();
                        plain_byte(c);
                    end else begin
                        held_cnt = 0;
                        phase = PH_IDLE;
                        take_tag(t, closing);
                        if (c == CH_SLASH) begin hold_byte(c); phase = PH_SLASHGT; end
                    end
                end else begin
                    release_held();
                    plain_byte(c);
                end
            PH_SLASHGT:
                if (c == CH_GT) begin held_cnt = 0; phase = PH_IDLE; end
                else begin release_held(); plain_byte(c); end
            default: begin
                phase = PH_IDLE;
                held_cnt = 0;
                plain_byte(c);
            end
        endcase
        if (last) begin
            release_held();
            if (styled_q.size() == n0) begin
                styled_t r;
                r = '0;
                r.ovf = ovf_flag;
                queue_styled(r);
            end
            styled_q[$].last = 1'b1;
            model_clear();
        end
    endfunction

    // drive one request and wait for its acceptance
    task automatic send_byte(logic [7:0] c, logic last);
        while (!tx_quiet && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tag_scan(c, last);
        @(negedge aclk);
    endtask

    task automatic send_text(string txt);
        for (int k = 0; k < txt.len(); k++) send_byte(txt[k], k == txt.len() - 1);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (styled_q.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (2 * STACK_DEPTH + 20) @(negedge aclk);
    endtask

    task automatic set_plain(logic v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        plain_mode = v;
    endtask

    // random case-varied spelling of a tag name
    function automatic string tag_text(int kind);
        string nm;
        case (kind)
            0: nm = "sup"; 1: nm = "sub"; 2: nm = "b"; 3: nm = "i";
            4: nm = "u";   5: nm = "s";   6: nm = "br"; default: nm = "p";
        endcase
        for (int k = 0; k < nm.len(); k++)
            if ($urandom_range(1)) nm[k] = nm[k] & ~CASE_BIT;
        return nm;
    endfunction

    // random fragment: mostly tags, some text, some noise and broken tags
    function automatic string random_piece();
        string p;
        int    sel;
        sel = $urandom_range(9);
        p = "";
        case (sel)
            0, 1, 2: p = {"<", tag_text($urandom_range(7)), ">"};
            3, 4:    p = {"</", tag_text($urandom_range(7)), ">"};
            5:       p = {"<", tag_text($urandom_range(7)), "/>"};
            6:       p = {"<", tag_text($urandom_range(7)),
                          $urandom_range(1) ? "/" : "", string'(8'($urandom_range(255)))};
            7:       p = {"<", $urandom_range(1) ? "/" : "", "abcd"};
            default: begin
                repeat ($urandom_range(1, 3)) p = {p, string'(8'($urandom_range(255)))};
            end
        endcase
        return p;
    endfunction

    // result side: random back-pressure and in-order compare
    always @(negedge aclk) begin
        if (aresetn) m_tready <= rx_quiet || ($urandom_range(99) >= 16);
    end

    always @(posedge aclk) begin
        styled_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ch = m_tdata[7:0];
            got.has = m_tuser;
            got.bold = m_tdata[8];
            got.italic = m_tdata[9];
            got.underline = m_tdata[10];
            got.strike = m_tdata[11];
            got.sup = m_tdata[12];
            got.sub = m_tdata[13];
            got.new_par = m_tdata[14];
            got.ovf = m_tdata[15];
            got.last = m_tlast;
            if (styled_q.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                want = styled_q.pop_front();
                if (pinned_q.size() != 0 && pinned_q[0].chk) begin
                    if (pinned_q[0].exp != want) begin
                        $error("table row disagrees: expected %h model %h",
                               pinned_q[0].exp, want);
                        errors++;
                    end
                end
                if (pinned_q.size() != 0) void'(pinned_q.pop_front());
                if (got.ch != want.ch) begin
                    $error("char_out expected %h actual %h", want.ch, got.ch); errors++; end
                if (got.has != want.has) begin
                    $error("has_char expected %b actual %b", want.has, got.has); errors++; end
                if (got.bold != want.bold) begin
                    $error("bold expected %b actual %b", want.bold, got.bold); errors++; end
                if (got.italic != want.italic) begin
                    $error("italic expected %b actual %b", want.italic, got.italic);
                    errors++;
                end
                if (got.underline != want.underline) begin
                    $error("underline expected %b actual %b", want.underline, got.underline);
                    errors++;
                end
                if (got.strike != want.strike) begin
                    $error("strike expected %b actual %b", want.strike, got.strike);
                    errors++;
                end
                if (got.sup != want.sup) begin
                    $error("superscript expected %b actual %b", want.sup, got.sup);
                    errors++;
                end
                if (got.sub != want.sub) begin
                    $error("subscript expected %b actual %b", want.sub, got.sub);
                    errors++;
                end
                if (got.new_par != want.new_par) begin
                    $error("new_paragraph expected %b actual %b", want.new_par, got.new_par);
                    errors++;
                end
                if (got.ovf != want.ovf) begin
                    $error("stack_overflow expected %b actual %b", want.ovf, got.ovf);
                    errors++;
                end
                if (got.last != want.last) begin
                    $error("last_out expected %b actual %b", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no request moving
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        row_t  table_rows [$];
        row_t  r;
        string txt;
        int    sent;
        int    n_made;
        plain_mode = 1'b0;
        model_clear();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: lone bytes with known results, then a tag whose bare end marker is known
        r = '{ch: 8'h00, last: 1'b1, chk: 1'b1, exp: '0};
        r.exp.has = 1'b1; r.exp.last = 1'b1;
        table_rows = {table_rows, r};
        r.ch = 8'hFF; r.exp.ch = 8'hFF;
        table_rows = {table_rows, r};
        r = '{ch: CH_LT, last: 1'b0, chk: 1'b0, exp: '0};
        table_rows = {table_rows, r};
        r.ch = "b"; table_rows = {table_rows, r};
        r.ch = CH_GT; r.last = 1'b1; r.chk = 1'b1;
        r.exp = '0; r.exp.last = 1'b1;     // bare end marker
        table_rows = {table_rows, r};
        // each row is pinned once per result it releases
        foreach (table_rows[k]) begin
            n_made = produced;
            send_byte(table_rows[k].ch, table_rows[k].last);
            for (int j = n_made; j < produced; j++) pinned_q = {pinned_q, table_rows[k]};
        end
        drain();
        pinned_q.delete();

        send_text("x<B>b<i>i<U>u<s>s</b>n<SUP>p<sub>q</SUP>r</x>");
        send_text("a<p><P>c<br>d<br/>e<p/>f</q>g<s/h<su");
        send_text("<i><b><u><s><i><b><u><s><i><b><u><s><i><b><u><s><b>x</b>y");
        send_text("<abcd><<b>");
        rx_quiet = 1'b1; tx_quiet = 1'b1;
        send_text("<b/z<br/q<>");
        rx_quiet = 1'b0; tx_quiet = 1'b0;

        set_plain(1'b1);
        send_text("<b>x<br>y<p>z</i><sup>w");
        set_plain(1'b0);

        // random well-formed-ish texts with random content
        sent = 0;
        while (sent < 120) begin
            if (sent > 30 && sent < 70) begin rx_quiet = 1'b1; tx_quiet = 1'b1; end
            else begin rx_quiet = 1'b0; tx_quiet = 1'b0; end
            if (sent >= 75 && sent < 100 && !plain_mode) set_plain(1'b1);
            else if (sent >= 100 && plain_mode) set_plain(1'b0);
            txt = "";
            repeat ($urandom_range(2, 12)) txt = {txt, random_piece()};
            send_text(txt);
            sent += txt.len();
        end

        drain();
        if (errors == 0 && styled_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
